// ===== design/sttt_pkg.sv =====
// ============================================================================
// Sensor trace track table package
// Shared sizes, request structs, status codes and lane result types.
// ============================================================================
package sttt_pkg;

    localparam int SENSORS       = 4;
    localparam int ENTRIES       = 64;
    localparam int ID_BITS       = 16;

    localparam int FIELD_SENSORS = 4;
    localparam int FIELD_ID_W    = 16;
    localparam int TRACK_W       = 7;

    localparam int LANES = (SENSORS < FIELD_SENSORS) ? SENSORS : FIELD_SENSORS;
    localparam int ID_W  = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [3:0]  sensor_present;
        logic [15:0] sensor_id_0;
        logic [15:0] sensor_id_1;
        logic [15:0] sensor_id_2;
        logic [15:0] sensor_id_3;
    } t_in_req;

    typedef struct packed {
        logic [6:0] track_id;
        logic       is_new;
        logic [1:0] status;
    } t_out_req;

    typedef struct packed {
        logic [LANES-1:0]           mask;
        logic [LANES-1:0][ID_W-1:0] ids;
    } t_entry;

    typedef struct packed {
        logic shared;
        logic conflict;
    } t_lane_res;

    function automatic logic [TRACK_W-1:0] to_track(input logic [CNT_W-1:0] v);
        logic [CNT_W+TRACK_W-1:0] ext;
        ext = {{TRACK_W{1'b0}}, v};
        return ext[TRACK_W-1:0];
    endfunction

endpackage

// ===== design/sttt_lane.sv =====
// ============================================================================
// Sensor lane compare
// Checks one sensor of a stored trace against the same sensor of the request.
// ============================================================================
module sttt_lane
    import sttt_pkg::*;
(
    input  logic            i_mask_st,
    input  logic            i_mask_req,
    input  logic [ID_W-1:0] i_id_st,
    input  logic [ID_W-1:0] i_id_req,
    output t_lane_res       o_res
);

    always_comb begin
        o_res.shared   = i_mask_st & i_mask_req;
        o_res.conflict = i_mask_st & i_mask_req & (i_id_st != i_id_req);
    end

endmodule

// ===== design/sttt_merge.sv =====
// ============================================================================
// Lane merge
// Combines the sensor lanes into one match decision for a stored trace.
// ============================================================================
module sttt_merge
    import sttt_pkg::*;
(
    input  t_lane_res [LANES-1:0] i_res,
    output logic                  o_match
);

    logic any_shared;
    logic any_conflict;

    always_comb begin
        any_shared   = 1'b0;
        any_conflict = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            any_shared   = any_shared | i_res[k].shared;
            any_conflict = any_conflict | i_res[k].conflict;
        end
        o_match = any_shared & ~any_conflict;
    end

endmodule

// ===== design/sensor_trace_track_id_table.sv =====
// ============================================================================
// Sensor trace track id table
// Maps per-sensor object traces to persistent fused track ids.
// ============================================================================
// Each input request carries a sensor mask and one object id per sensor.
// Both channels use valid and ready; one result request follows each input.
// The table is scanned in ascending track id order, one stored trace per
// cycle, with the sensor lanes comparing in parallel. The first match is
// overwritten and returns its id; otherwise the next id is allocated.
// A scan reads at most N stored traces, where N is the number of allocated
// track ids (at most ENTRIES), one at a time through the single read port.
// Input ready is high only while the block is idle. A finished result sits
// in an output register, so the next request is accepted while it waits;
// a stalled receiver holds the following result until the register frees.
// Reset empties the table by clearing the allocation count; stored traces
// need no clearing since only allocated entries are read.
// An empty mask returns status empty; a full table with no match returns
// status full and track id 0.
// ============================================================================
module sensor_trace_track_id_table
    import sttt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] n_issue;
    logic             r_cmp_valid;
    logic             n_cmp_valid;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [IDX_W-1:0] n_cmp_idx;
    t_entry           r_item;
    t_entry           n_item;
    t_out_req         r_res;
    t_out_req         n_res;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_req         r_out;
    t_out_req         n_out;

    t_entry           r_mem [ENTRIES];
    t_entry           r_rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;

    t_entry           req_entry;
    logic [FIELD_SENSORS-1:0][FIELD_ID_W-1:0] field_ids;
    t_lane_res [LANES-1:0] lane_res;
    logic             match;
    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] hit_track;
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        field_ids[0] = i_in_req.sensor_id_0;
        field_ids[1] = i_in_req.sensor_id_1;
        field_ids[2] = i_in_req.sensor_id_2;
        field_ids[3] = i_in_req.sensor_id_3;
        for (int k = 0; k < LANES; k++) begin
            req_entry.mask[k] = i_in_req.sensor_present[k];
            req_entry.ids[k]  = field_ids[k][ID_W-1:0];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sttt_lane u_lane (
            .i_mask_st  (r_rd_data.mask[g]),
            .i_mask_req (r_item.mask[g]),
            .i_id_st    (r_rd_data.ids[g]),
            .i_id_req   (r_item.ids[g]),
            .o_res      (lane_res[g])
        );
    end

    sttt_merge u_merge (
        .i_res   (lane_res),
        .o_match (match)
    );

    assign accept    = i_in_valid & o_in_ready;
    assign out_free  = ~r_out_valid | i_out_ready;
    assign hit_track = {{(CNT_W-IDX_W){1'b0}}, r_cmp_idx} + CNT_W'(1);
    assign cnt_next  = r_count + CNT_W'(1);
    assign rd_en     = (r_state == S_SCAN) && (r_issue != r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_item      = r_item;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_idx      = r_cmp_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item      = req_entry;
                    n_issue     = '0;
                    n_cmp_valid = 1'b0;
                    if (req_entry.mask == '0) begin
                        n_res.track_id = '0;
                        n_res.is_new   = 1'b0;
                        n_res.status   = ST_EMPTY;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmp_valid && match) begin
                    wr_en          = 1'b1;
                    wr_idx         = r_cmp_idx;
                    n_res.track_id = to_track(hit_track);
                    n_res.is_new   = 1'b0;
                    n_res.status   = ST_OK;
                    n_state        = S_DONE;
                end else if (r_issue == r_count) begin
                    if (r_count == CNT_W'(ENTRIES)) begin
                        n_res.track_id = '0;
                        n_res.is_new   = 1'b0;
                        n_res.status   = ST_FULL;
                    end else begin
                        wr_en          = 1'b1;
                        wr_idx         = r_count[IDX_W-1:0];
                        n_count        = cnt_next;
                        n_res.track_id = to_track(cnt_next);
                        n_res.is_new   = 1'b1;
                        n_res.status   = ST_OK;
                    end
                    n_state = S_DONE;
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_issue[IDX_W-1:0];
                    n_issue     = r_issue + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= r_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_issue[IDX_W-1:0]];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("allocation count beyond table size");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmp_valid) |->
            ({{(CNT_W-IDX_W){1'b0}}, r_cmp_idx} < r_count))
        else $error("compare of an unallocated entry");

    a_ok_has_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status == ST_OK) |-> (o_out_req.track_id != '0))
        else $error("ok result without a track id");

    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_DONE && n_res.is_new) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("new track without allocation");

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// Sensor trace track id table testbench
// Drives sensor traces through the valid/ready request channel and checks
// every returned track id, allocation flag and status against an in-bench
// prediction of the trace table, under random idling on both sides.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sttt_pkg::*;

    class track_scoreboard;
        int unsigned      n_alloc = 0;
        logic [LANES-1:0] trk_mask [ENTRIES];
        logic [ID_W-1:0]  trk_ids [ENTRIES][LANES];
        t_out_req         pending_q [$];
        int unsigned      n_checked = 0;
        int unsigned      n_errors = 0;
        int unsigned      n_fresh = 0;
        int unsigned      n_matched = 0;
        int unsigned      n_empty = 0;
        int unsigned      n_full = 0;

        function void note_request(t_in_req r);
            logic [15:0]      raw [FIELD_SENSORS];
            logic [ID_W-1:0]  ids [LANES];
            logic [LANES-1:0] m;
            logic [LANES-1:0] shared;
            logic             ok;
            int               hit;
            t_out_req         res;
            raw[0] = r.sensor_id_0;
            raw[1] = r.sensor_id_1;
            raw[2] = r.sensor_id_2;
            raw[3] = r.sensor_id_3;
            m = r.sensor_present[LANES-1:0];
            for (int k = 0; k < LANES; k++) begin
                ids[k] = raw[k][ID_W-1:0];
            end
            res = '0;
            res.status = ST_OK;
            hit = -1;
            if (m == '0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                for (int e = 0; e < n_alloc && hit < 0; e++) begin
                    shared = trk_mask[e] & m;
                    ok = (shared != '0);
                    for (int k = 0; k < LANES; k++) begin
                        if (shared[k] && trk_ids[e][k] != ids[k]) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        hit = e;
                    end
                end
                if (hit >= 0) begin
                    n_matched++;
                end else if (n_alloc < ENTRIES) begin
                    hit = n_alloc;
                    n_alloc++;
                    res.is_new = 1'b1;
                    n_fresh++;
                end
                if (hit < 0) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    trk_mask[hit] = m;
                    for (int k = 0; k < LANES; k++) begin
                        trk_ids[hit][k] = ids[k];
                    end
                    res.track_id = 7'(hit + 1);
                end
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected result: track %0d new %0d status %0d",
                             got.track_id, got.is_new, got.status);
                end
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got.track_id !== want.track_id || got.is_new !== want.is_new ||
                got.status !== want.status) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch on result %0d: expected track %0d new %0d status %0d",
                             n_checked, want.track_id, want.is_new, want.status);
                    $display("    got track %0d new %0d status %0d",
                             got.track_id, got.is_new, got.status);
                end
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_req;

    track_scoreboard sb = new;
    bit              long_stall_done = 1'b0;

    sensor_trace_track_id_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in_req);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_req);
            end
        end
    end

    function automatic t_in_req make_trace(logic [3:0] m, logic [15:0] a, logic [15:0] b,
                                           logic [15:0] c, logic [15:0] d);
        t_in_req r;
        r.sensor_present = m;
        r.sensor_id_0 = a;
        r.sensor_id_1 = b;
        r.sensor_id_2 = c;
        r.sensor_id_3 = d;
        return r;
    endfunction

    task automatic send_trace(input t_in_req r, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req = r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Result side: random stalls, one long hold-off to back up the block,
    // and a window of back-to-back acceptance.
    initial begin
        int w;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!long_stall_done && sb.n_checked >= 120) begin
                i_out_ready = 1'b0;
                repeat (300) @(negedge i_clk);
                long_stall_done = 1'b1;
            end
            w = (sb.n_checked >= 350 && sb.n_checked < 420) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                i_out_ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        t_in_req directed_q [$];
        t_in_req hist_q [$];
        t_in_req r;
        int      sel;
        bit      failed;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_q.push_back(make_trace(4'h0, 16'h1234, 16'h0, 16'hFFFF, 16'h5));
        directed_q.push_back(make_trace(4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_q.push_back(make_trace(4'h1, 16'h0000, 16'h0, 16'h0, 16'h0));
        directed_q.push_back(make_trace(4'h1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_q.push_back(make_trace(4'h2, 16'h0, 16'hFFFF, 16'h0, 16'h0));
        directed_q.push_back(make_trace(4'h3, 16'h0, 16'hFFFF, 16'h0, 16'h0));
        directed_q.push_back(make_trace(4'h2, 16'h7, 16'hFFFF, 16'h0, 16'h0));
        directed_q.push_back(make_trace(4'h4, 16'h0, 16'h0, 16'h1234, 16'h0));
        directed_q.push_back(make_trace(4'h8, 16'h0, 16'h0, 16'h0, 16'hFFFF));
        directed_q.push_back(make_trace(4'hF, 16'h0, 16'hFFFF, 16'h1234, 16'hFFFF));
        directed_q.push_back(make_trace(4'hF, 16'h0, 16'hFFFF, 16'h1235, 16'hFFFF));
        directed_q.push_back(make_trace(4'hC, 16'h0, 16'h0, 16'hAAAA, 16'h5555));
        directed_q.push_back(make_trace(4'h8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555));
        directed_q.push_back(make_trace(4'h1, 16'hFFFF, 16'h0, 16'h0, 16'h0));
        directed_q.push_back(make_trace(4'h5, 16'h8000, 16'h0, 16'h0001, 16'h0));
        directed_q.push_back(make_trace(4'hA, 16'h0, 16'h8000, 16'h0, 16'h0001));
        directed_q.push_back(make_trace(4'h6, 16'h0, 16'h8000, 16'hAAAA, 16'h0));
        directed_q.push_back(make_trace(4'h9, 16'h5555, 16'h0, 16'h0, 16'h0001));
        directed_q.push_back(make_trace(4'h0, 16'h0, 16'h0, 16'h0, 16'h0));
        foreach (directed_q[i]) begin
            send_trace(directed_q[i], (i % 2) == 1);
            hist_q.push_back(directed_q[i]);
        end

        // Half of the traces revisit earlier ones, often with a changed mask or
        // one id, so matches, conflicts and overwrites are common; the rest are
        // fresh traces from a small id pool or fully random ones.
        for (int n = 0; n < 500; n++) begin
            if (n == 300) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                r = hist_q[$urandom_range(0, hist_q.size() - 1)];
                if ($urandom_range(0, 1)) begin
                    r.sensor_present = r.sensor_present ^ 4'($urandom_range(0, 15));
                end
                case ($urandom_range(0, 7))
                    0: r.sensor_id_0 = 16'($urandom_range(0, 7));
                    1: r.sensor_id_1 = 16'($urandom_range(0, 7));
                    2: r.sensor_id_2 = 16'($urandom_range(0, 7));
                    3: r.sensor_id_3 = 16'($urandom_range(0, 7));
                    default: ;
                endcase
            end else if (sel < 85) begin
                r = make_trace(4'($urandom_range(0, 15)), 16'($urandom_range(0, 7)),
                               16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                               16'($urandom_range(0, 7)));
            end else begin
                r = make_trace(4'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom));
            end
            send_trace(r, n >= 200 && n < 260);
            hist_q.push_back(r);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("checked %0d results: %0d new tracks, %0d matched, %0d empty, %0d full",
                 sb.n_checked, sb.n_fresh, sb.n_matched, sb.n_empty, sb.n_full);
        $display("table ended with %0d of %0d track ids allocated, %0d mismatches",
                 sb.n_alloc, ENTRIES, sb.n_errors);
        failed = (sb.n_errors != 0) || (sb.pending_q.size() != 0);
        if (!failed) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/sttt_pkg.sv
design/sttt_lane.sv
design/sttt_merge.sv
design/sensor_trace_track_id_table.sv
tb/tb.sv
